/* hdl/bgs_pkg.sv */
package bgs_pkg;

	localparam int MAX_PARTS_DEF   = 4;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int PARTS_W         = 3;
	localparam int FRAC_W          = 16;

	// 1/sqrt(2) in Q0.16
	localparam logic [FRAC_W-1:0] ISQ2_Q16 = 16'd46341;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUBE,
		ST_CHECK,
		ST_BND,
		ST_DIV,
		ST_EMIT
	} bgs_st_t;

	typedef enum logic [2:0] {
		CB_IDLE,
		CB_ORDER,
		CB_MUL,
		CB_CMP_S,
		CB_CMP_T
	} cube_st_t;

endpackage

/* hdl/bgs_div.sv */
module bgs_div import bgs_pkg::*; #(
	parameter int UW = COORD_WIDTH_DEF + 5,
	parameter int BW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [UW-1:0] num,
	input  logic [BW-1:0] den,
	output logic          done,
	output logic [UW-1:0] quo
);

	localparam int CW = $clog2(UW + 1);

	logic [UW-1:0] num_q;
	logic [BW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [BW:0]   r2;
	logic          take;

	// restoring division, one quotient bit per cycle; quotient shifts in behind the dividend
	assign r2   = {rem_q, num_q[UW-1]};
	assign take = (r2 >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(UW);
			end else if (busy_q) begin
				busy_q <= (cnt_q != CW'(1));
				cnt_q  <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[UW-2:0], take};
			rem_q <= take ? BW'(r2 - {1'b0, den}) : r2[BW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

/* hdl/bgs_cube.sv */
module bgs_cube import bgs_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] ext_x,
	input  logic signed [W-1:0] ext_y,
	input  logic signed [W-1:0] ext_z,
	output logic                done,
	output logic [2:0]          single
);

	localparam int PW = W + FRAC_W + 1;

	cube_st_t st_q, st_d;
	axis_t    big_q, mid_q, sml_q;
	axis_t    o_big, o_mid, o_sml;
	logic signed [PW-1:0] prod_q;
	logic signed [W-1:0]  ext_big, ext_mid, ext_sml;
	logic [2:0] single_q;
	logic       done_q;
	logic       gt_mid, gt_sml;
	logic       xy, yz, xz;

	// largest extent, the runner-up, and the smallest, with ties resolved toward x then y
	always_comb begin
		xy = (ext_x >= ext_y);
		yz = (ext_y >= ext_z);
		xz = (ext_x >= ext_z);
		if (xy) begin
			if (yz) begin
				o_big = AX_X; o_mid = AX_Y; o_sml = AX_Z;
			end else if (xz) begin
				o_big = AX_X; o_mid = AX_Z; o_sml = AX_Y;
			end else begin
				o_big = AX_Z; o_mid = AX_X; o_sml = AX_Y;
			end
		end else begin
			if (xz) begin
				o_big = AX_Y; o_mid = AX_X; o_sml = AX_Z;
			end else if (yz) begin
				o_big = AX_Y; o_mid = AX_Z; o_sml = AX_X;
			end else begin
				o_big = AX_Z; o_mid = AX_Y; o_sml = AX_X;
			end
		end
	end

	always_comb begin
		case (big_q)
			AX_X:    ext_big = ext_x;
			AX_Y:    ext_big = ext_y;
			default: ext_big = ext_z;
		endcase
		case (mid_q)
			AX_X:    ext_mid = ext_x;
			AX_Y:    ext_mid = ext_y;
			default: ext_mid = ext_z;
		endcase
		case (sml_q)
			AX_X:    ext_sml = ext_x;
			AX_Y:    ext_sml = ext_y;
			default: ext_sml = ext_z;
		endcase
	end

	// big * 46341 > other * 65536
	assign gt_mid = (prod_q > $signed({ext_mid[W-1], ext_mid, FRAC_W'(0)}));
	assign gt_sml = (prod_q > $signed({ext_sml[W-1], ext_sml, FRAC_W'(0)}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CB_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			CB_IDLE:  if (start) st_d = CB_ORDER;
			CB_ORDER: st_d = CB_MUL;
			CB_MUL:   st_d = CB_CMP_S;
			CB_CMP_S: st_d = gt_mid ? CB_IDLE : CB_CMP_T;
			CB_CMP_T: st_d = CB_IDLE;
			default:  st_d = CB_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ((st_q == CB_CMP_S) && gt_mid) || (st_q == CB_CMP_T);
			if (start) begin
				single_q <= '0;
			end else if (st_q == CB_CMP_S && gt_mid) begin
				single_q[mid_q] <= 1'b1;
				single_q[sml_q] <= 1'b1;
			end else if (st_q == CB_CMP_T && gt_sml) begin
				single_q[sml_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == CB_ORDER) begin
			big_q <= o_big;
			mid_q <= o_mid;
			sml_q <= o_sml;
		end
		if (st_q == CB_MUL) begin
			prod_q <= ext_big * $signed({1'b0, ISQ2_Q16});
		end
	end

	assign done   = done_q;
	assign single = single_q;

endmodule

/* hdl/box_grid_subdivider.sv */
// channel | direction | handshake             | payload
// input   | in        | in_valid / in_ready   | op, min/max x y z, parts_x/y/z
// output  | out       | out_valid / out_ready | sub_min/max x y z, last
//
// Per box: a check of the part counts (after the cube-like choice in that mode),
// then each interior boundary in turn, all of them going through one bit-serial
// divider (3 per axis, 9 at most for 4 parts per axis), then one sub-box per
// cycle while out_ready is high. in_ready is high only between boxes.
// A waiting sub-box in the output register does not block the next request.
// Reset is asynchronous and clears only control state.
module box_grid_subdivider import bgs_pkg::*; #(
	parameter int MAX_PARTS   = MAX_PARTS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_WIDTH-1:0] min_x,
	input  logic signed [COORD_WIDTH-1:0] max_x,
	input  logic signed [COORD_WIDTH-1:0] min_y,
	input  logic signed [COORD_WIDTH-1:0] max_y,
	input  logic signed [COORD_WIDTH-1:0] min_z,
	input  logic signed [COORD_WIDTH-1:0] max_z,
	input  logic [PARTS_W-1:0]           parts_x,
	input  logic [PARTS_W-1:0]           parts_y,
	input  logic [PARTS_W-1:0]           parts_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_WIDTH-1:0] sub_min_x,
	output logic signed [COORD_WIDTH-1:0] sub_max_x,
	output logic signed [COORD_WIDTH-1:0] sub_min_y,
	output logic signed [COORD_WIDTH-1:0] sub_max_y,
	output logic signed [COORD_WIDTH-1:0] sub_min_z,
	output logic signed [COORD_WIDTH-1:0] sub_max_z,
	output logic                         last
);

	localparam int W    = COORD_WIDTH;
	localparam int PMAX = (MAX_PARTS < 2) ? 2 : MAX_PARTS;
	localparam int BW   = $clog2(PMAX + 1);
	localparam int UW   = W + 5;
	localparam int NAX  = 3;

	bgs_st_t st_q, st_d;

	logic signed [W-1:0] in_lo [NAX];
	logic signed [W-1:0] in_hi [NAX];
	logic [PARTS_W-1:0]  in_parts [NAX];

	logic signed [W-1:0] lo_q [NAX];
	logic signed [W:0]   d_q [NAX];
	logic [BW-1:0]       p_q [NAX];
	logic signed [W-1:0] bnd_q [NAX][PMAX+1];
	logic signed [W-1:0] c_lo_q [NAX];
	logic signed [W-1:0] c_hi_q [NAX];
	logic [BW-1:0]       i_q [NAX];
	logic signed [W-1:0] sub_lo_q [NAX];
	logic signed [W-1:0] sub_hi_q [NAX];
	logic                last_q;
	logic                out_valid_q;
	axis_t               ax_q;
	logic [BW-1:0]       k_q;

	logic signed [W-1:0] ext [NAX];
	logic [BW-1:0]       nxt_i [NAX];
	logic [NAX-1:0]      wrap, adv;
	logic                last_c;

	logic                in_acc;
	logic                div_start, div_done, cube_start, cube_done;
	logic                emit_go, emit_init;
	logic [UW-1:0]       div_num, div_quo;
	logic [2:0]          single;
	logic signed [W:0]   d_sel;
	logic [BW-1:0]       p_sel;
	logic signed [W-1:0] lo_sel;
	logic signed [W+BW+1:0] dk;

	always_comb begin
		in_lo[0] = min_x; in_hi[0] = max_x; in_parts[0] = parts_x;
		in_lo[1] = min_y; in_hi[1] = max_y; in_parts[1] = parts_y;
		in_lo[2] = min_z; in_hi[2] = max_z; in_parts[2] = parts_z;
	end

	assign in_acc = in_valid && in_ready;

	// saturated extents for the cube-like choice
	always_comb begin
		for (int a = 0; a < NAX; a++) begin
			if (d_q[a][W] != d_q[a][W-1]) begin
				ext[a] = d_q[a][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				ext[a] = d_q[a][W-1:0];
			end
		end
	end

	// numerator biased by p * 2^(W+2) so it stays positive; the bias drops out of the low W bits
	assign d_sel   = d_q[ax_q];
	assign p_sel   = p_q[ax_q];
	assign lo_sel  = lo_q[ax_q];
	assign dk      = d_sel * $signed({1'b0, k_q});
	assign div_num = UW'(dk) + (UW'(p_sel) << (W + 2));

	bgs_div #(
		.UW (UW),
		.BW (BW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (p_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	bgs_cube #(
		.W (W)
	) u_cube (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cube_start),
		.ext_x  (ext[0]),
		.ext_y  (ext[1]),
		.ext_z  (ext[2]),
		.done   (cube_done),
		.single (single)
	);

	// grid walk: x fastest, carry into y, then z
	always_comb begin
		for (int a = 0; a < NAX; a++) begin
			wrap[a]  = (i_q[a] == p_q[a] - BW'(1));
			nxt_i[a] = i_q[a] + BW'(2);
		end
		adv[0] = 1'b1;
		for (int a = 1; a < NAX; a++) begin
			adv[a] = adv[a-1] && wrap[a-1];
		end
		last_c = &wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		cube_start = 1'b0;
		emit_go    = 1'b0;
		emit_init  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op) begin
						cube_start = 1'b1;
						st_d       = ST_CUBE;
					end else begin
						st_d = ST_CHECK;
					end
				end
			end
			ST_CUBE: begin
				if (cube_done) st_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (p_q[0] == '0 || p_q[1] == '0 || p_q[2] == '0) begin
					st_d = ST_IDLE;
				end else begin
					st_d = ST_BND;
				end
			end
			ST_BND: begin
				if (k_q >= p_sel) begin
					if (ax_q == AX_Z) begin
						emit_init = 1'b1;
						st_d      = ST_EMIT;
					end
				end else begin
					div_start = 1'b1;
					st_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) st_d = ST_BND;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_go = 1'b1;
					if (last_c) st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ax_q        <= AX_X;
			k_q         <= '0;
			for (int a = 0; a < NAX; a++) i_q[a] <= '0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				ax_q <= AX_X;
				k_q  <= BW'(1);
			end else if (st_q == ST_BND && k_q >= p_sel && ax_q != AX_Z) begin
				ax_q <= (ax_q == AX_X) ? AX_Y : AX_Z;
				k_q  <= BW'(1);
			end else if (st_q == ST_DIV && div_done) begin
				k_q <= k_q + BW'(1);
			end

			if (emit_init) begin
				for (int a = 0; a < NAX; a++) i_q[a] <= '0;
			end else if (emit_go) begin
				for (int a = 0; a < NAX; a++) begin
					if (adv[a]) i_q[a] <= wrap[a] ? '0 : i_q[a] + BW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int a = 0; a < NAX; a++) begin
				lo_q[a] <= in_lo[a];
				d_q[a]  <= {in_hi[a][W-1], in_hi[a]} - {in_lo[a][W-1], in_lo[a]};
				p_q[a]  <= (in_parts[a] > PARTS_W'(MAX_PARTS)) ? BW'(MAX_PARTS)
				                                               : BW'(in_parts[a]);
				// edge 0 is min; everything above is max until interior edges land
				for (int e = 0; e <= PMAX; e++) begin
					bnd_q[a][e] <= (e == 0) ? in_lo[a] : in_hi[a];
				end
			end
		end
		if (st_q == ST_CUBE && cube_done) begin
			for (int a = 0; a < NAX; a++) begin
				p_q[a] <= single[a] ? BW'(1) : BW'(2);
			end
		end
		if (st_q == ST_DIV && div_done) begin
			bnd_q[ax_q][k_q] <= lo_sel + div_quo[W-1:0];
		end
		if (emit_init) begin
			for (int a = 0; a < NAX; a++) begin
				c_lo_q[a] <= bnd_q[a][0];
				c_hi_q[a] <= bnd_q[a][1];
			end
		end else if (emit_go) begin
			for (int a = 0; a < NAX; a++) begin
				if (adv[a]) begin
					if (wrap[a]) begin
						c_lo_q[a] <= bnd_q[a][0];
						c_hi_q[a] <= bnd_q[a][1];
					end else begin
						c_lo_q[a] <= c_hi_q[a];
						c_hi_q[a] <= bnd_q[a][nxt_i[a]];
					end
				end
			end
		end
		if (emit_go) begin
			for (int a = 0; a < NAX; a++) begin
				sub_lo_q[a] <= c_lo_q[a];
				sub_hi_q[a] <= c_hi_q[a];
			end
			last_q <= last_c;
		end
	end

	assign out_valid = out_valid_q;
	assign sub_min_x = sub_lo_q[0];
	assign sub_max_x = sub_hi_q[0];
	assign sub_min_y = sub_lo_q[1];
	assign sub_max_y = sub_hi_q[1];
	assign sub_min_z = sub_lo_q[2];
	assign sub_max_z = sub_hi_q[2];
	assign last      = last_q;

endmodule

/* bench/box_grid_subdivider_tb.sv */
module box_grid_subdivider_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bgs_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam longint SPAN_HI = (longint'(1) << (CW - 1)) - 1;
	localparam longint SPAN_LO = -SPAN_HI - 1;
	localparam longint ONE_Q = longint'(1) << FRAC_W;

	typedef enum logic {
		OP_EXPLICIT = 1'b0,
		OP_CUBE     = 1'b1
	} split_op_t;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

	typedef struct {
		split_op_t          op;
		coord_t             lo[3];
		coord_t             hi[3];
		logic [PARTS_W-1:0] parts[3];
	} box_req_t;

	typedef struct {
		coord_t lo[3];
		coord_t hi[3];
		logic   last;
	} sub_box_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	coord_t             min_x, max_x, min_y, max_y, min_z, max_z;
	logic [PARTS_W-1:0] parts_x, parts_y, parts_z;
	logic               out_valid;
	logic               out_ready;
	coord_t             sub_min_x, sub_max_x, sub_min_y, sub_max_y, sub_min_z, sub_max_z;
	logic               last;

	sub_box_t pending_subs[$];
	int       mismatch_count = 0;
	bit       idle_on = 1'b1;
	int       hold_left = 0;

	box_grid_subdivider #(
		.MAX_PARTS  (MAX_PARTS_DEF),
		.COORD_WIDTH(CW)
	) DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 900000);
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic longint sat_span(longint lo, longint hi);
		longint e;
		e = hi - lo;
		if (e > SPAN_HI)
			return SPAN_HI;
		if (e < SPAN_LO)
			return SPAN_LO;
		return e;
	endfunction

	// a / sqrt(2) > b, done exactly in Q16
	function automatic bit tilt_gt(longint a, longint b);
		return a * longint'(ISQ2_Q16) > b * ONE_Q;
	endfunction

	function automatic longint axis_edge(longint lo, longint hi, int k, int p);
		longint num, q;
		if (k == 0)
			return lo;
		if (k >= p)
			return hi;
		num = (hi - lo) * longint'(k);
		q = num / longint'(p);
		// round toward minus infinity
		if ((num % longint'(p)) != 0 && num < 0)
			q = q - 1;
		return lo + q;
	endfunction

	function automatic void pick_cube_counts(longint x, longint y, longint z, output int c[3]);
		c[0] = 2;
		c[1] = 2;
		c[2] = 2;
		if (x >= y) begin
			if (y >= z) begin
				if (tilt_gt(x, y)) begin
					c[1] = 1;
					c[2] = 1;
				end else if (tilt_gt(x, z)) begin
					c[2] = 1;
				end
			end else if (x >= z) begin
				if (tilt_gt(x, z)) begin
					c[1] = 1;
					c[2] = 1;
				end else if (tilt_gt(x, y)) begin
					c[1] = 1;
				end
			end else begin
				if (tilt_gt(z, x)) begin
					c[0] = 1;
					c[1] = 1;
				end else if (tilt_gt(z, y)) begin
					c[1] = 1;
				end
			end
		end else begin
			if (x >= z) begin
				if (tilt_gt(y, x)) begin
					c[0] = 1;
					c[2] = 1;
				end else if (tilt_gt(y, z)) begin
					c[2] = 1;
				end
			end else if (y >= z) begin
				if (tilt_gt(y, z)) begin
					c[0] = 1;
					c[2] = 1;
				end else if (tilt_gt(y, x)) begin
					c[0] = 1;
				end
			end else begin
				if (tilt_gt(z, y)) begin
					c[0] = 1;
					c[1] = 1;
				end else if (tilt_gt(z, x)) begin
					c[0] = 1;
				end
			end
		end
	endfunction

	// queues every sub-box that one accepted request should produce
	function automatic void split_into_grid(box_req_t b);
		longint lo[3], hi[3];
		int cnt[3];
		int a, ix, iy, iz, total, n;
		sub_box_t s;
		for (a = 0; a < 3; a++) begin
			lo[a] = b.lo[a];
			hi[a] = b.hi[a];
		end
		if (b.op == OP_CUBE) begin
			pick_cube_counts(sat_span(lo[0], hi[0]), sat_span(lo[1], hi[1]),
				sat_span(lo[2], hi[2]), cnt);
		end else begin
			for (a = 0; a < 3; a++)
				cnt[a] = (b.parts[a] > MAX_PARTS_DEF) ? MAX_PARTS_DEF : int'(b.parts[a]);
		end
		total = cnt[0] * cnt[1] * cnt[2];
		n = 0;
		for (iz = 0; iz < cnt[2]; iz++) begin
			for (iy = 0; iy < cnt[1]; iy++) begin
				for (ix = 0; ix < cnt[0]; ix++) begin
					s.lo[0] = coord_t'(axis_edge(lo[0], hi[0], ix, cnt[0]));
					s.hi[0] = coord_t'(axis_edge(lo[0], hi[0], ix + 1, cnt[0]));
					s.lo[1] = coord_t'(axis_edge(lo[1], hi[1], iy, cnt[1]));
					s.hi[1] = coord_t'(axis_edge(lo[1], hi[1], iy + 1, cnt[1]));
					s.lo[2] = coord_t'(axis_edge(lo[2], hi[2], iz, cnt[2]));
					s.hi[2] = coord_t'(axis_edge(lo[2], hi[2], iz + 1, cnt[2]));
					n++;
					s.last = (n == total);
					pending_subs.push_back(s);
				end
			end
		end
	endfunction

	// ---------------- checking ----------------

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		sub_box_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_subs.size() == 0) begin
				$error("sub-box out with no request pending");
				mismatch_count++;
			end else begin
				want = pending_subs.pop_front();
				check_field("sub_min_x", want.lo[0], sub_min_x);
				check_field("sub_max_x", want.hi[0], sub_max_x);
				check_field("sub_min_y", want.lo[1], sub_min_y);
				check_field("sub_max_y", want.hi[1], sub_max_y);
				check_field("sub_min_z", want.lo[2], sub_min_z);
				check_field("sub_max_z", want.hi[2], sub_max_z);
				check_field("last", want.last, last);
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when asked for
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (idle_on) begin
				out_ready <= ($urandom_range(99) >= 37);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------- stimulus ----------------

	function automatic box_req_t mk_box(split_op_t o, coord_t x0, coord_t x1, coord_t y0,
			coord_t y1, coord_t z0, coord_t z1, int px = 1, int py = 1, int pz = 1);
		box_req_t b;
		b.op = o;
		b.lo[0] = x0;
		b.hi[0] = x1;
		b.lo[1] = y0;
		b.hi[1] = y1;
		b.lo[2] = z0;
		b.hi[2] = z1;
		b.parts[0] = px[PARTS_W-1:0];
		b.parts[1] = py[PARTS_W-1:0];
		b.parts[2] = pz[PARTS_W-1:0];
		return b;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return C_MIN;
					1: return C_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			1: return coord_t'($urandom_range(0, 1 << 21)) - coord_t'(1 << 20);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic box_req_t rand_box();
		box_req_t b;
		int a;
		b.op = ($urandom_range(99) < 40) ? OP_CUBE : OP_EXPLICIT;
		for (a = 0; a < 3; a++) begin
			b.lo[a] = rand_coord();
			if ($urandom_range(1))
				b.hi[a] = rand_coord();
			else
				b.hi[a] = b.lo[a] + coord_t'($urandom_range(0, 1 << 22));
			// mostly legal counts, now and then zero or above the limit
			if ($urandom_range(9) == 0)
				b.parts[a] = PARTS_W'($urandom_range(7));
			else
				b.parts[a] = PARTS_W'($urandom_range(1, 4));
		end
		return b;
	endfunction

	task automatic send_box(input box_req_t b);
		if (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 37);
		end
		in_valid <= 1'b1;
		op       <= b.op;
		min_x    <= b.lo[0];
		max_x    <= b.hi[0];
		min_y    <= b.lo[1];
		max_y    <= b.hi[1];
		min_z    <= b.lo[2];
		max_z    <= b.hi[2];
		parts_x  <= b.parts[0];
		parts_y  <= b.parts[1];
		parts_z  <= b.parts[2];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		split_into_grid(b);
	endtask

	task automatic test_single_part();
		send_box(mk_box(OP_EXPLICIT, C_MIN, C_MAX, -65536, 65536, 0, 0, 1, 1, 1));
		send_box(mk_box(OP_EXPLICIT, C_MAX, C_MAX, C_MIN, C_MIN, '1, '1, 1, 1, 1));
	endtask

	task automatic test_zero_counts();
		send_box(mk_box(OP_EXPLICIT, 0, 65536, 0, 65536, 0, 65536, 0, 2, 2));
		send_box(mk_box(OP_EXPLICIT, 0, 65536, 0, 65536, 0, 65536, 2, 0, 2));
		send_box(mk_box(OP_EXPLICIT, 0, 65536, 0, 65536, 0, 65536, 2, 2, 0));
		send_box(mk_box(OP_EXPLICIT, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0, 0, 0));
	endtask

	task automatic test_full_grid();
		send_box(mk_box(OP_EXPLICIT, C_MIN, C_MAX, C_MAX, C_MIN, 0, 3, 4, 4, 4));
		send_box(mk_box(OP_EXPLICIT, 0, 10, -10, 0, 1, 2, 3, 3, 4));
	endtask

	task automatic test_count_clamp();
		send_box(mk_box(OP_EXPLICIT, -1000, 1000, 7, 7, 0, 99999, 5, 6, 7));
		send_box(mk_box(OP_EXPLICIT, 12345, 67890, 0, 1, 0, 1, 7, 1, 1));
	endtask

	task automatic test_inverted_box();
		send_box(mk_box(OP_EXPLICIT, 100, -100, 7, -8, -1, -2, 3, 3, 2));
	endtask

	task automatic test_cube_choice();
		// count fields must be ignored here, so give zeros
		send_box(mk_box(OP_CUBE, 0, 100000, 0, 100000, 0, 100000, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 400000, 0, 65536, 0, 65536, 0, 0, 0));
		// exactly on the 1/sqrt(2) threshold on y, just past it on z
		send_box(mk_box(OP_CUBE, 0, 65536, 0, 46341, 0, 46340, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 200000, 0, 50000, 0, 200000, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 100000, 0, 100000, 0, 300000, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 50000, 0, 300000, 0, 50000, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 10000, 0, 300000, 0, 290000, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 60000, 0, 90000, 0, 100000, 7, 7, 7));
		// spans saturate both ways
		send_box(mk_box(OP_CUBE, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 300000, 0, 65536, 0, 0, -65536, 0, 0, 0));
		send_box(mk_box(OP_CUBE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_receiver_hold();
		int i;
		hold_left = 400;
		for (i = 0; i < 5; i++)
			send_box(mk_box(OP_EXPLICIT, rand_coord(), rand_coord(), -65536, 65536,
				0, 131072, 2, 2, 2));
	endtask

	task automatic test_sender_pause();
		int i;
		for (i = 0; i < 3; i++)
			send_box(rand_box());
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_subs.size() != 0);
		for (i = 0; i < 3; i++)
			send_box(rand_box());
	endtask

	task automatic test_random_boxes();
		int i;
		for (i = 0; i < 50; i++)
			send_box(rand_box());
		idle_on = 1'b0;
		for (i = 0; i < 30; i++)
			send_box(rand_box());
		idle_on = 1'b1;
		for (i = 0; i < 47; i++)
			send_box(rand_box());
	endtask

	initial begin
		int wait_cycles;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		op       <= OP_EXPLICIT;
		min_x    <= '0;
		max_x    <= '0;
		min_y    <= '0;
		max_y    <= '0;
		min_z    <= '0;
		max_z    <= '0;
		parts_x  <= '0;
		parts_y  <= '0;
		parts_z  <= '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_part();
		test_zero_counts();
		test_full_grid();
		test_count_clamp();
		test_inverted_box();
		test_cube_choice();
		test_receiver_hold();
		test_sender_pause();
		test_random_boxes();

		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_subs.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_subs.size() != 0) begin
			$error("%0d sub-boxes never arrived", pending_subs.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			// let any late extra output show up
			repeat (300)
				@(posedge clk);
			if (mismatch_count == 0)
				$display("Simulation PASSED");
			else
				$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
